// File: rtl/sra_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sra_pkg
// Shared types and constants for the slice rate allocator.
// ----------------------------------------------------------------------------
package sra_pkg;

  localparam int MAX_SLICES_DEF = 8;

  // Datapath widths
  localparam int RATE_W = 24;   // Q8 rates
  localparam int CAP_W  = 26;   // total_prbs * rate_per_prb
  localparam int WT_W   = 33;   // unmet demand * (1 + priority)
  localparam int PROD_W = WT_W + CAP_W;
  localparam int SAT_W  = 17;
  localparam int DVD_W  = 60;   // divider dividend / quotient width
  localparam int DVS_W  = 40;   // divider divisor width
  localparam int CNT_W  = $clog2(DVD_W + 1);

  localparam logic [SAT_W-1:0] SAT_FULL = 17'h10000;

  // Configuration register indexes
  localparam logic REG_TOTAL_PRBS   = 1'b0;
  localparam logic REG_RATE_PER_PRB = 1'b1;

  typedef struct packed {
    logic [31:0]       slice_key;
    logic [RATE_W-1:0] min_rate;
    logic [RATE_W-1:0] max_rate;
    logic [7:0]        priority_req;
    logic [RATE_W-1:0] demand;
    logic [15:0]       share_weight;
    logic              share_given;
    logic              use_shares;
    logic              last_slice;
  } slice_req_t;

  typedef struct packed {
    logic [31:0]       result_key;
    logic [RATE_W-1:0] demand_out;
    logic [RATE_W-1:0] served_rate;
    logic [9:0]        prbs_allocated;
    logic [SAT_W-1:0]  satisfaction;
    logic              min_met;
    logic [SAT_W-1:0]  mean_satisfaction;
    logic              last_result;
  } slice_res_t;

  // Request to the shared divider
  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

endpackage
`default_nettype wire

// File: rtl/sra_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sra_div
// Restoring divider, one quotient bit per cycle; a start during a division restarts it.
// ----------------------------------------------------------------------------
module sra_div (
  input  wire                      clk,
  input  wire                      rst,
  input  wire sra_pkg::div_req_t   req,
  output logic                     done,
  output logic [sra_pkg::DVD_W-1:0] quot
);
  import sra_pkg::*;

  logic             run;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W:0]   part;
  logic [DVS_W:0]   shifted;
  logic             ge;

  // Shift the next dividend bit into the partial remainder and try subtract
  assign shifted = {part[DVS_W-1:0], quot[DVD_W-1]};
  assign ge      = shifted >= {1'b0, dvs};

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        cnt <= CNT_W'(DVD_W);
      end else if (run) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      quot <= req.dividend;
      part <= '0;
      dvs  <= req.divisor;
    end else if (run) begin
      part <= ge ? (shifted - {1'b0, dvs}) : shifted;
      quot <= {quot[DVD_W-2:0], ge};
    end
  end

`ifndef SYNTH
  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    req.start |=> run) else $error("divider did not start");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !run) else $error("divider done while running");
  a_last_step: assert property (@(posedge clk) disable iff (rst)
    (run && cnt == CNT_W'(1) && !req.start) |=> done)
    else $error("divider missed completion");
`endif

endmodule
`default_nettype wire

// File: rtl/slice_rate_allocator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slice_rate_allocator_core
// Allocates per-round capacity among slices: minimum reservation, then a
// share- or priority-weighted split of the remainder, one result per slice.
// ----------------------------------------------------------------------------
// A request that is not marked last is stored while the table has room. The
// last request (also stored if there is room) starts a round over the n
// stored slices, unless total_prbs or n is zero, with busy high throughout:
// a reservation pass and a weight pass over the slices, then per slice a
// product and a division for the extra share (both skipped when the weights
// sum to zero), a setup step and a division for the PRB count, the same for
// satisfaction, an accumulate step and an emit step; before the last emit,
// a division for the mean. A zero rate per PRB or a zero demand skips the
// matching division. All divisions use the single shared divider.
// Results come out one per strobe cycle on res/res_valid and must be taken
// then: the receiver cannot stall them. Configuration writes are taken while
// not busy.
module slice_rate_allocator_core #(
  parameter int MAX_SLICES = sra_pkg::MAX_SLICES_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  output logic                busy,
  input  wire sra_pkg::slice_req_t req,
  output logic                res_valid,
  output sra_pkg::slice_res_t res,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire                 cfg_index,
  input  wire [15:0]          cfg_data
);
  import sra_pkg::*;

  localparam int CW     = $clog2(MAX_SLICES + 1);
  localparam int IW     = (MAX_SLICES > 1) ? $clog2(MAX_SLICES) : 1;
  localparam int WSUM_W = WT_W + CW;
  localparam int SSUM_W = SAT_W + CW;

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_RESV  = 12'b0000_0000_0010,
    ST_WGT   = 12'b0000_0000_0100,
    ST_MUL   = 12'b0000_0000_1000,
    ST_DIVX  = 12'b0000_0001_0000,
    ST_SERVE = 12'b0000_0010_0000,
    ST_DIVP  = 12'b0000_0100_0000,
    ST_SAT   = 12'b0000_1000_0000,
    ST_DIVS  = 12'b0001_0000_0000,
    ST_SUM   = 12'b0010_0000_0000,
    ST_DIVM  = 12'b0100_0000_0000,
    ST_EMIT  = 12'b1000_0000_0000
  } state_t;

  state_t state;

  // Configuration
  logic [9:0]  total_prbs;
  logic [15:0] rate_per_prb;

  // Slice tables
  logic [31:0]       key_tab   [MAX_SLICES];
  logic [RATE_W-1:0] min_tab   [MAX_SLICES];
  logic [RATE_W-1:0] cap_tab   [MAX_SLICES];
  logic [7:0]        pri_tab   [MAX_SLICES];
  logic [RATE_W-1:0] dem_tab   [MAX_SLICES];
  logic [16:0]       share_tab [MAX_SLICES];
  logic [RATE_W-1:0] resv_tab  [MAX_SLICES];
  logic [WT_W-1:0]   wt_tab    [MAX_SLICES];
  logic [CAP_W-1:0]  ext_tab   [MAX_SLICES];

  logic [CW-1:0]     entry_count;
  logic [CW-1:0]     n_r;
  logic [IW-1:0]     idx;
  logic [CAP_W-1:0]  cap_r;
  logic [CAP_W-1:0]  used;
  logic              any_share;
  logic              mode;
  logic              zero_sum;
  logic [WSUM_W-1:0] wsum;
  logic [PROD_W-1:0] prod;
  logic [RATE_W-1:0] served_r;
  logic [9:0]        prbs_r;
  logic [SAT_W-1:0]  sat_r;
  logic [SSUM_W-1:0] sat_sum;
  logic [SAT_W-1:0]  mean_r;
  logic              div_start;

  // Divider
  div_req_t          dreq;
  logic              div_done;
  logic [DVD_W-1:0]  div_q;

  // Combinational helpers
  logic              stored;
  logic [CW-1:0]     cnt_after;
  logic              last_idx;
  logic [CAP_W-1:0]  rem;
  logic [RATE_W-1:0] cur_min, cur_dem, cur_cap, cur_res, unmet;
  logic [CAP_W-1:0]  resv_cur;
  logic [WT_W-1:0]   w_cur;
  logic [WSUM_W-1:0] wsum_next;
  logic [WT_W-1:0]   mul_a;
  logic [CAP_W-1:0]  mul_b;
  logic [PROD_W-1:0] mul_p;
  logic [CAP_W:0]    tot;
  logic [RATE_W-1:0] served_d;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = !busy;

  assign stored    = entry_count < CW'(MAX_SLICES);
  assign cnt_after = stored ? entry_count + CW'(1) : entry_count;
  assign last_idx  = (CW'(idx) == n_r - CW'(1));
  assign rem       = cap_r - used;

  assign cur_min = min_tab[idx];
  assign cur_dem = dem_tab[idx];
  assign cur_cap = cap_tab[idx];
  assign cur_res = resv_tab[idx];
  assign unmet   = cur_dem - cur_res;

  // Reserve min(minimum, demand, remaining capacity)
  always_comb begin
    resv_cur = CAP_W'(cur_min);
    if (CAP_W'(cur_dem) < resv_cur) resv_cur = CAP_W'(cur_dem);
    if (rem < resv_cur) resv_cur = rem;
  end

  // Shared multiplier: weights in the weight pass, rem * weight later
  assign mul_a = (state == ST_MUL) ? wt_tab[idx] : WT_W'(unmet);
  assign mul_b = (state == ST_MUL) ? rem : CAP_W'({1'b0, pri_tab[idx]} + 9'd1);
  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  always_comb begin
    if (mode && any_share)
      w_cur = share_tab[idx][16] ? WT_W'(share_tab[idx][15:0]) : '0;
    else
      w_cur = mul_p[WT_W-1:0];
  end
  assign wsum_next = wsum + WSUM_W'(w_cur);

  // Served rate, clamped by demand and cap
  always_comb begin
    tot = (CAP_W+1)'(cur_res) + (zero_sum ? '0 : (CAP_W+1)'(ext_tab[idx]));
    served_d = (tot < (CAP_W+1)'(cur_dem)) ? tot[RATE_W-1:0] : cur_dem;
    if (cur_cap != '0 && cur_cap < served_d) served_d = cur_cap;
  end

  // Divider operand selection
  always_comb begin
    dreq.start = div_start;
    case (state)
      ST_DIVX: begin
        dreq.dividend = DVD_W'(prod);
        dreq.divisor  = DVS_W'(wsum);
      end
      ST_DIVP: begin
        dreq.dividend = DVD_W'(served_r) + DVD_W'(rate_per_prb) - DVD_W'(1);
        dreq.divisor  = DVS_W'(rate_per_prb);
      end
      ST_DIVS: begin
        dreq.dividend = DVD_W'({served_r, 16'h0000});
        dreq.divisor  = DVS_W'(cur_dem);
      end
      ST_DIVM: begin
        dreq.dividend = DVD_W'(sat_sum);
        dreq.divisor  = DVS_W'(n_r);
      end
      default: begin
        dreq.dividend = '0;
        dreq.divisor  = '0;
      end
    endcase
  end

  sra_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (dreq),
    .done (div_done),
    .quot (div_q)
  );

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      entry_count  <= '0;
      div_start    <= 1'b0;
      res_valid    <= 1'b0;
      total_prbs   <= '0;
      rate_per_prb <= 16'd256;
      idx          <= '0;
    end else begin
      res_valid <= 1'b0;
      div_start <= 1'b0;

      // Take configuration writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TOTAL_PRBS:   total_prbs   <= cfg_data[9:0];
          REG_RATE_PER_PRB: rate_per_prb <= cfg_data;
          default:          ;
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (start) begin
            if (stored) begin
              key_tab[entry_count[IW-1:0]]   <= req.slice_key;
              min_tab[entry_count[IW-1:0]]   <= req.min_rate;
              cap_tab[entry_count[IW-1:0]]   <= req.max_rate;
              pri_tab[entry_count[IW-1:0]]   <= req.priority_req;
              dem_tab[entry_count[IW-1:0]]   <= req.demand;
              share_tab[entry_count[IW-1:0]] <= {req.share_given, req.share_weight};
            end
            if (req.last_slice) begin
              entry_count <= '0;
              n_r         <= cnt_after;
              cap_r       <= CAP_W'(total_prbs) * CAP_W'(rate_per_prb);
              used        <= '0;
              any_share   <= 1'b0;
              mode        <= req.use_shares;
              sat_sum     <= '0;
              idx         <= '0;
              if (total_prbs != '0 && cnt_after != '0) state <= ST_RESV;
            end else begin
              entry_count <= cnt_after;
            end
          end
        end
        ST_RESV: begin
          resv_tab[idx] <= resv_cur[RATE_W-1:0];
          used          <= used + resv_cur;
          any_share     <= any_share | share_tab[idx][16];
          if (last_idx) begin
            idx   <= '0;
            wsum  <= '0;
            state <= ST_WGT;
          end else begin
            idx <= idx + IW'(1);
          end
        end
        ST_WGT: begin
          wt_tab[idx] <= w_cur;
          wsum        <= wsum_next;
          if (last_idx) begin
            idx      <= '0;
            zero_sum <= (wsum_next == '0);
            state    <= (wsum_next == '0) ? ST_SERVE : ST_MUL;
          end else begin
            idx <= idx + IW'(1);
          end
        end
        ST_MUL: begin
          prod      <= mul_p;
          div_start <= 1'b1;
          state     <= ST_DIVX;
        end
        ST_DIVX: begin
          if (div_done) begin
            ext_tab[idx] <= div_q[CAP_W-1:0];
            if (last_idx) begin
              idx   <= '0;
              state <= ST_SERVE;
            end else begin
              idx   <= idx + IW'(1);
              state <= ST_MUL;
            end
          end
        end
        ST_SERVE: begin
          served_r <= served_d;
          if (rate_per_prb == '0) begin
            prbs_r <= (served_d != '0) ? total_prbs : '0;
            state  <= ST_SAT;
          end else begin
            div_start <= 1'b1;
            state     <= ST_DIVP;
          end
        end
        ST_DIVP: begin
          if (div_done) begin
            prbs_r <= (div_q > DVD_W'(total_prbs)) ? total_prbs : div_q[9:0];
            state  <= ST_SAT;
          end
        end
        ST_SAT: begin
          if (cur_dem == '0) begin
            sat_r <= SAT_FULL;
            state <= ST_SUM;
          end else begin
            div_start <= 1'b1;
            state     <= ST_DIVS;
          end
        end
        ST_DIVS: begin
          if (div_done) begin
            sat_r <= (div_q > DVD_W'(SAT_FULL)) ? SAT_FULL : div_q[SAT_W-1:0];
            state <= ST_SUM;
          end
        end
        ST_SUM: begin
          sat_sum <= sat_sum + SSUM_W'(sat_r);
          if (last_idx) begin
            div_start <= 1'b1;
            state     <= ST_DIVM;
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_DIVM: begin
          if (div_done) begin
            mean_r <= div_q[SAT_W-1:0];
            state  <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          res_valid             <= 1'b1;
          res.result_key        <= key_tab[idx];
          res.demand_out        <= cur_dem;
          res.served_rate       <= served_r;
          res.prbs_allocated    <= prbs_r;
          res.satisfaction      <= sat_r;
          res.min_met           <= (served_r >= cur_min);
          res.mean_satisfaction <= last_idx ? mean_r : '0;
          res.last_result       <= last_idx;
          if (last_idx) begin
            state <= ST_IDLE;
          end else begin
            idx   <= idx + IW'(1);
            state <= ST_SERVE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_res_from_emit: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> $past(state == ST_EMIT)) else $error("result outside emit");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(MAX_SLICES)) else $error("slice count overflow");
  a_div_state: assert property (@(posedge clk) disable iff (rst)
    div_start |-> (state == ST_DIVX || state == ST_DIVP ||
                   state == ST_DIVS || state == ST_DIVM))
    else $error("divider started outside a divide state");
`endif

endmodule
`default_nettype wire
